// ===== hdl/cse_pkg.sv =====
// Shared types and constants of the CAN signal extractor.
// No dependencies; imported by every module of the block.
package cse_pkg;

  // Request kinds carried on the input tuser bit
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FRAME = 1'b1;

  // Frame length is clamped to this many bytes
  localparam logic [3:0] MAX_LEN = 4'd8;

  // Hit queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // Product magnitude cap and signed Q47.16 limits
  localparam logic [63:0] PROD_CAP = 64'h8000_0001_0000_0000;
  localparam logic [63:0] POS_LIM  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIM  = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_WALK,
    FE_FLUSH
  } cse_fe_state_t;

  // Input tdata, last field in the lowest bits
  typedef struct packed {
    logic [5:0]  pad;
    logic [31:0] offset;
    logic [31:0] scale;
    logic [5:0]  bit_shift;
    logic [6:0]  bit_count;
    logic        big_endian;
    logic [2:0]  last_byte;
    logic [2:0]  first_byte;
    logic [4:0]  entry_index;
    logic [3:0]  length;
    logic [63:0] payload;
    logic [28:0] can_id;
  } cse_in_t;

  // Output tdata, last field in the lowest bits
  typedef struct packed {
    logic [2:0]  pad;
    logic [31:0] seen_mask;
    logic [63:0] value;
    logic [4:0]  field_index;
  } cse_out_t;

  // One table entry: byte layout part
  typedef struct packed {
    logic [5:0]  bit_shift;
    logic [6:0]  bit_count;
    logic        big_endian;
    logic [2:0]  last_byte;
    logic [2:0]  first_byte;
    logic [28:0] can_id;
  } cse_layout_t;

  // One table entry: scaling part
  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] scale;
  } cse_scaling_t;

  // Result bookkeeping that rides along the back pipeline
  typedef struct packed {
    logic        matched;
    logic [4:0]  field_index;
    logic [31:0] seen_mask;
    logic        last;
  } cse_meta_t;

  // One decode job handed from front to back
  typedef struct packed {
    cse_meta_t    meta;
    cse_layout_t  layout;
    cse_scaling_t scaling;
    logic [63:0]  payload;
  } cse_job_t;

endpackage

// ===== hdl/can_signal_extractor_unit.sv =====
// Top level of the CAN signal extractor: front walk, hit queue, back pipeline.
// Depends on cse_pkg, cse_front, cse_queue and cse_back.
//
//  Channel | Direction | Handshake           | Contents
//  in_     | input     | in_tvalid/in_tready | tuser: req_type; tdata: load or frame fields
//  out_    | output    | out_tvalid/tready   | tuser: matched; tdata: result; tlast: last
//  cfg_    | input     | cfg_valid/cfg_ready | entry count register (ready out of reset)
//
// A load is written to the table memory as it is accepted. A frame blocks the
// input until its walk is done and its final job is queued: the front reads one
// table entry per cycle from its table memory while the walk is not paused.
// Results leave one per cycle when the output is not stalled. A full hit queue pauses
// the walk when a hit must be pushed; a stalled output freezes the back pipeline.
// Reset clears control state only; table entries are undefined until loaded.
module can_signal_extractor_unit
  import cse_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tuser,   // [0] req_type
  // [28:0] can_id, [92:29] payload, [96:93] length, [101:97] entry_index,
  // [104:102] first_byte, [107:105] last_byte, [108] big_endian,
  // [115:109] bit_count, [121:116] bit_shift, [153:122] scale,
  // [185:154] offset, [191:186] zero
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_tlast,
  output logic         out_tuser,  // [0] matched
  // [4:0] field_index, [68:5] value, [100:69] seen_mask, [103:101] zero
  output logic [103:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [5:0]   cfg_data
);

  logic     q_push;
  cse_job_t q_push_data;
  logic     q_full;
  logic     q_pop;
  logic     q_vld;
  cse_job_t q_head;

  cse_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_push     (q_push),
    .q_push_data(q_push_data),
    .q_full     (q_full)
  );

  cse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_data),
    .full     (q_full),
    .pop      (q_pop),
    .head_vld (q_vld),
    .head_data(q_head)
  );

  cse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

endmodule

// ===== hdl/cse_front.sv =====
// Front end: table memory, load handling and the per-frame table walk.
// Depends on cse_pkg; pushes decode jobs into cse_queue.
module cse_front
  import cse_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       in_tuser,
  input  logic [191:0] in_tdata,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data,
  output logic       q_push,
  output cse_job_t   q_push_data,
  input  logic       q_full
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  cse_layout_t  lay_mem [TABLE_DEPTH];
  cse_scaling_t scl_mem [TABLE_DEPTH];

  cse_fe_state_t    state_r, state_nxt;
  logic [5:0]       tcount_r;
  logic [CNT_W-1:0] cnt_lim_r, cnt_lim_nxt;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  cse_job_t         pend_r, pend_nxt;
  logic [31:0]      mask_r, mask_nxt;
  logic [28:0]      id_r, id_nxt;
  logic [63:0]      payload_r, payload_nxt;
  logic [3:0]       len_r, len_nxt;
  cse_layout_t      lay_rd_r;
  cse_scaling_t     scl_rd_r;

  cse_in_t          in_f;
  logic             in_acc;
  logic             load_we;
  logic [6:0]       lim_full;
  logic [CNT_W-1:0] cnt_lim;
  logic             rd_en;
  logic             hit;
  logic             stall;
  cse_job_t         hit_job;
  cse_job_t         flush_job;

  assign in_f   = cse_in_t'(in_tdata);
  assign in_acc = in_tvalid && in_tready;
  assign load_we = in_acc && (in_tuser == REQ_LOAD) &&
                   (6'(in_f.entry_index) < 6'(TABLE_DEPTH));
  // Register write taken whenever out of reset
  assign cfg_ready = rst_n;

  // Entries walked: register value clamped to the table depth
  assign lim_full = (7'(tcount_r) > 7'(TABLE_DEPTH)) ? 7'(TABLE_DEPTH) : 7'(tcount_r);
  assign cnt_lim  = lim_full[CNT_W-1:0];

  // Match check on the table entry held in the read register
  assign hit = cmp_vld_r && (lay_rd_r.can_id == id_r) &&
               ({1'b0, lay_rd_r.last_byte} < len_r);
  assign stall = (state_r == FE_WALK) && hit && pend_vld_r && q_full;
  assign rd_en = (state_r == FE_WALK) && !stall && (rd_cnt_r < cnt_lim_r);

  // Job built from a hit
  always_comb begin
    hit_job                   = '0;
    hit_job.meta.matched      = 1'b1;
    hit_job.meta.field_index  = 5'(cmp_idx_r);
    hit_job.meta.seen_mask    = mask_r | (32'd1 << cmp_idx_r);
    hit_job.meta.last         = 1'b0;
    hit_job.layout            = lay_rd_r;
    hit_job.scaling           = scl_rd_r;
    hit_job.payload           = payload_r;
  end

  // Final job of a frame: pending hit marked last, or the no-hit result
  always_comb begin
    flush_job = '0;
    if (pend_vld_r) begin
      flush_job = pend_r;
    end
    flush_job.meta.last = 1'b1;
  end

  // Next state and queue push
  always_comb begin
    state_nxt    = state_r;
    cnt_lim_nxt  = cnt_lim_r;
    rd_cnt_nxt   = rd_cnt_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_idx_nxt  = cmp_idx_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    mask_nxt     = mask_r;
    id_nxt       = id_r;
    payload_nxt  = payload_r;
    len_nxt      = len_r;
    in_tready    = 1'b0;
    q_push       = 1'b0;
    q_push_data  = pend_r;
    case (state_r)
      FE_IDLE: begin
        in_tready = rst_n;
        if (in_acc && (in_tuser == REQ_FRAME)) begin
          id_nxt       = in_f.can_id;
          payload_nxt  = in_f.payload;
          len_nxt      = (in_f.length > MAX_LEN) ? MAX_LEN : in_f.length;
          cnt_lim_nxt  = cnt_lim;
          rd_cnt_nxt   = '0;
          cmp_vld_nxt  = 1'b0;
          pend_vld_nxt = 1'b0;
          mask_nxt     = '0;
          state_nxt    = FE_WALK;
        end
      end
      FE_WALK: begin
        if (!stall) begin
          cmp_vld_nxt = rd_en;
          cmp_idx_nxt = rd_cnt_r[IDX_W-1:0];
          rd_cnt_nxt  = rd_cnt_r + CNT_W'(rd_en);
          if (hit) begin
            q_push       = pend_vld_r;
            q_push_data  = pend_r;
            pend_nxt     = hit_job;
            pend_vld_nxt = 1'b1;
            mask_nxt     = hit_job.meta.seen_mask;
          end
          if (rd_cnt_r == cnt_lim_r) begin
            state_nxt = FE_FLUSH;
          end
        end
      end
      FE_FLUSH: begin
        q_push_data = flush_job;
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = FE_IDLE;
        end
      end
      default: begin
        state_nxt = FE_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= FE_IDLE;
      tcount_r   <= '0;
      cmp_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      rd_cnt_r   <= '0;
      cnt_lim_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
      cnt_lim_r  <= cnt_lim_nxt;
      if (cfg_valid && cfg_ready) begin
        tcount_r <= cfg_data;
      end
    end
  end

  // Frame data and walk payload
  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    pend_r    <= pend_nxt;
    mask_r    <= mask_nxt;
    id_r      <= id_nxt;
    payload_r <= payload_nxt;
    len_r     <= len_nxt;
  end

  // Table memory: written by loads, read one entry per unstalled walk cycle
  always_ff @(posedge clk) begin
    if (load_we) begin
      lay_mem[in_f.entry_index[IDX_W-1:0]] <= '{
        bit_shift:  in_f.bit_shift,
        bit_count:  in_f.bit_count,
        big_endian: in_f.big_endian,
        last_byte:  in_f.last_byte,
        first_byte: in_f.first_byte,
        can_id:     in_f.can_id
      };
      scl_mem[in_f.entry_index[IDX_W-1:0]] <= '{offset: in_f.offset, scale: in_f.scale};
    end
    if (rd_en) begin
      lay_rd_r <= lay_mem[rd_cnt_r[IDX_W-1:0]];
      scl_rd_r <= scl_mem[rd_cnt_r[IDX_W-1:0]];
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("front pushed into a full queue");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FE_WALK) |-> (rd_cnt_r <= cnt_lim_r))
    else $error("walk counter ran past the entry count");

  a_frame_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == REQ_FRAME)) |=> (state_r == FE_WALK) && !pend_vld_r)
    else $error("frame accepted without starting a fresh walk");

endmodule

// ===== hdl/cse_queue.sv =====
// Short FIFO of decode jobs between the front walk and the back pipeline.
// Depends on cse_pkg for the job type and depth.
module cse_queue
  import cse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  cse_job_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     head_vld,
  output cse_job_t head_data
);

  cse_job_t           slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r;
  logic               do_push;
  logic               do_pop;

  assign full      = (cnt_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign head_vld  = (cnt_r != '0);
  assign head_data = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && head_vld;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (Q_PTR_W + 1)'(do_push) - (Q_PTR_W + 1)'(do_pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_vld)
    else $error("pop from an empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("fill count did not follow a push");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_PTR_W + 1)'(Q_DEPTH))
    else $error("fill count above queue depth");

endmodule

// ===== hdl/cse_back.sv =====
// Back end: byte assembly, bit-field extract, Q16.16 scale and offset,
// saturation into Q47.16, and the output register. Depends on cse_pkg.
module cse_back
  import cse_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_vld,
  input  cse_job_t     q_data,
  output logic         q_pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_tlast,
  output logic         out_tuser,
  output logic [103:0] out_tdata
);

  logic adv;

  // Stage 1: assembled bytes
  logic              s1_vld_r;
  cse_meta_t         s1_meta_r;
  logic [63:0]       s1_asm_r;
  logic              s1_narrow_r;
  logic [5:0]        s1_sh_r;
  logic [6:0]        s1_bits_r;
  logic [31:0]       s1_smag_r;
  logic              s1_sneg_r;
  logic [31:0]       s1_off_r;
  // Stage 2: raw field
  logic              s2_vld_r;
  cse_meta_t         s2_meta_r;
  logic [63:0]       s2_raw_r;
  logic [31:0]       s2_smag_r;
  logic              s2_sneg_r;
  logic [31:0]       s2_off_r;
  // Stage 3: partial products
  logic              s3_vld_r;
  cse_meta_t         s3_meta_r;
  logic [63:0]       s3_plo_r;
  logic [63:0]       s3_phi_r;
  logic              s3_sneg_r;
  logic [31:0]       s3_off_r;
  // Stage 4: capped product magnitude
  logic              s4_vld_r;
  cse_meta_t         s4_meta_r;
  logic [63:0]       s4_pmag_r;
  logic              s4_pneg_r;
  logic [31:0]       s4_off_r;
  // Stage 5: signed product
  logic              s5_vld_r;
  cse_meta_t         s5_meta_r;
  logic [64:0]       s5_pval_r;
  logic [31:0]       s5_off_r;
  // Output register
  logic              out_vld_r;
  cse_meta_t         out_meta_r;
  logic [63:0]       out_value_r;

  logic [3:0]        span;
  logic              rev;
  logic [2:0]        bsel;
  logic [63:0]       asm_v;
  logic [63:0]       fmask;
  logic [63:0]       raw_v;
  logic [95:0]       prod;
  logic [65:0]       sum;
  logic [63:0]       sat_v;
  cse_out_t          out_f;

  // Whole pipeline moves when the output register can take a result
  assign adv   = !out_vld_r || out_tready;
  assign q_pop = adv && q_vld;

  // Byte assembly, little- or big-endian over the span
  assign rev  = (q_data.layout.last_byte < q_data.layout.first_byte);
  assign span = 4'(q_data.layout.last_byte) - 4'(q_data.layout.first_byte) + 4'd1;
  always_comb begin
    asm_v = '0;
    bsel  = '0;
    for (int k = 0; k < 8; k++) begin
      bsel = q_data.layout.big_endian ? (q_data.layout.last_byte - 3'(k))
                                      : (q_data.layout.first_byte + 3'(k));
      if (!rev && (4'(k) < span)) begin
        asm_v[8*k +: 8] = q_data.payload[{bsel, 3'b000} +: 8];
      end
    end
  end

  // Shift and mask for a field narrower than the span
  assign fmask = (64'd1 << s1_bits_r) - 64'd1;
  assign raw_v = s1_narrow_r ? ((s1_asm_r >> s1_sh_r) & fmask) : s1_asm_r;

  // Product recombination
  assign prod = {32'd0, s3_plo_r} + {s3_phi_r, 32'd0};

  // Offset add and saturation
  assign sum = {s5_pval_r[64], s5_pval_r} + {{34{s5_off_r[31]}}, s5_off_r};
  always_comb begin
    if (sum[65:63] == 3'b000 || sum[65:63] == 3'b111) begin
      sat_v = sum[63:0];
    end else if (sum[65]) begin
      sat_v = NEG_LIM;
    end else begin
      sat_v = POS_LIM;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= q_vld;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;
      out_vld_r <= s5_vld_r;
    end
  end

  // Stage data
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta_r   <= q_data.meta;
      s1_asm_r    <= asm_v;
      s1_narrow_r <= (q_data.layout.bit_count < {span, 3'b000});
      s1_sh_r     <= q_data.layout.bit_shift;
      s1_bits_r   <= q_data.layout.bit_count;
      s1_sneg_r   <= q_data.scaling.scale[31];
      s1_smag_r   <= q_data.scaling.scale[31] ? (~q_data.scaling.scale + 32'd1)
                                              : q_data.scaling.scale;
      s1_off_r    <= q_data.scaling.offset;

      s2_meta_r <= s1_meta_r;
      s2_raw_r  <= raw_v;
      s2_smag_r <= s1_smag_r;
      s2_sneg_r <= s1_sneg_r;
      s2_off_r  <= s1_off_r;

      s3_meta_r <= s2_meta_r;
      s3_plo_r  <= s2_raw_r[31:0] * s2_smag_r;
      s3_phi_r  <= s2_raw_r[63:32] * s2_smag_r;
      s3_sneg_r <= s2_sneg_r;
      s3_off_r  <= s2_off_r;

      s4_meta_r <= s3_meta_r;
      s4_pmag_r <= (prod > {32'd0, PROD_CAP}) ? PROD_CAP : prod[63:0];
      s4_pneg_r <= s3_sneg_r && (prod != '0);
      s4_off_r  <= s3_off_r;

      s5_meta_r <= s4_meta_r;
      s5_pval_r <= s4_pneg_r ? (65'd0 - {1'b0, s4_pmag_r}) : {1'b0, s4_pmag_r};
      s5_off_r  <= s4_off_r;

      out_meta_r  <= s5_meta_r;
      out_value_r <= s5_meta_r.matched ? sat_v : 64'd0;
    end
  end

  // Output packing
  always_comb begin
    out_f              = '0;
    out_f.field_index  = out_meta_r.field_index;
    out_f.value        = out_value_r;
    out_f.seen_mask    = out_meta_r.seen_mask;
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_meta_r.last;
  assign out_tuser  = out_meta_r.matched;
  assign out_tdata  = out_f;

  a_nohit_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_meta_r.matched) |->
      (out_value_r == '0) && out_meta_r.last && (out_meta_r.seen_mask == '0))
    else $error("no-hit result not in its fixed form");

  a_mask_has_self: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_meta_r.matched) |->
      out_meta_r.seen_mask[out_meta_r.field_index])
    else $error("update mask misses the reported index");

  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> s1_vld_r)
    else $error("popped job lost before the first stage");

endmodule
